// ===== hw/rtl/rgb_to_hsl_converter_top_defines.svh =====
`ifndef RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define R2HSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r2hsl check failed");

// check cons in the cycle after ante
`define R2HSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r2hsl check failed");

`endif

// ===== hw/rtl/r2hsl_pkg.sv =====
`timescale 1ns / 1ps

package r2hsl_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int HUE_FRAC_BITS  = 6;

    localparam int HUE_W = 15;
    localparam int SAT_W = 8;
    localparam int LX2_W = 9;

    localparam int SUM_W = COMPONENT_BITS + 1;
    localparam int HA_W  = HUE_FRAC_BITS + 9;
    localparam int HQ_W  = HUE_FRAC_BITS + 7;
    localparam int HN_W  = COMPONENT_BITS + HQ_W;
    localparam int SQ_W  = 8;
    localparam int SN_W  = COMPONENT_BITS + SQ_W;
    localparam int DIV_STAGES = (HQ_W > SQ_W) ? HQ_W : SQ_W;

    localparam logic [SUM_W-1:0] CH_MAX    = SUM_W'((1 << COMPONENT_BITS) - 1);
    localparam logic [SUM_W-1:0] CH_MAX_X2 = SUM_W'(2 * ((1 << COMPONENT_BITS) - 1));
    localparam logic [SN_W-1:0]  SAT_SCALE = SN_W'(255);

    localparam logic [HA_W-1:0] HUE_SECTOR = HA_W'(60 << HUE_FRAC_BITS);
    localparam logic [HA_W-1:0] FULL_TURN  = HA_W'(360 << HUE_FRAC_BITS);

    localparam logic [HA_W-1:0] HUE_OFS_RED_POS = '0;
    localparam logic [HA_W-1:0] HUE_OFS_GREEN   = HA_W'(60 << HUE_FRAC_BITS);
    localparam logic [HA_W-1:0] HUE_OFS_BLUE    = HA_W'(180 << HUE_FRAC_BITS);
    localparam logic [HA_W-1:0] HUE_OFS_RED_NEG = HA_W'(300 << HUE_FRAC_BITS);

    typedef logic [COMPONENT_BITS-1:0] chan_t;
    typedef logic [SUM_W-1:0]          sum_t;
    typedef logic [HA_W-1:0]           hacc_t;

    typedef struct packed {
        chan_t            d;
        chan_t            den;
        chan_t            hrem;
        logic [HQ_W-1:0]  hq;
        chan_t            srem;
        logic [SQ_W-1:0]  sq;
        hacc_t            ofs;
        sum_t             sum;
        logic             zero;
    } div_t;

    function automatic div_t div_step(input div_t s, input logic hue_on, input logic sat_on);
        div_t                  o;
        logic [COMPONENT_BITS:0] ht;
        logic [COMPONENT_BITS:0] st;
        o  = s;
        ht = {s.hrem, s.hq[HQ_W-1]};
        st = {s.srem, s.sq[SQ_W-1]};
        if (hue_on)
        begin
            if (ht >= {1'b0, s.d})
            begin
                o.hrem = COMPONENT_BITS'(ht - {1'b0, s.d});
                o.hq   = {s.hq[HQ_W-2:0], 1'b1};
            end
            else
            begin
                o.hrem = ht[COMPONENT_BITS-1:0];
                o.hq   = {s.hq[HQ_W-2:0], 1'b0};
            end
        end
        if (sat_on)
        begin
            if (st >= {1'b0, s.den})
            begin
                o.srem = COMPONENT_BITS'(st - {1'b0, s.den});
                o.sq   = {s.sq[SQ_W-2:0], 1'b1};
            end
            else
            begin
                o.srem = st[COMPONENT_BITS-1:0];
                o.sq   = {s.sq[SQ_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/rgb_to_hsl_converter_top.sv =====
`timescale 1ns / 1ps

// RGB to HSL pixel converter.
// Input channel: pixel_valid / pixel_ready with red, green, blue (8 bits each).
// Output channel: result_valid / result_ready with hue (1/64 degree units,
// 0..23039), saturation (0..255) and lightness_x2 (max + min, 0..510).
// A word is taken on each edge where valid and ready are both high.
// A pixel accepted on the input passes through three front stages, one
// numerator stage, thirteen divider stages and one output stage to the result
// port. The hue quotient is built one bit per stage by a pipelined restoring
// divider, the saturation quotient likewise in parallel.
// Throughput: one pixel per clock while result_ready stays high.
// Every stage holds its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles close up during a stall and the input
// keeps being accepted until the whole pipeline is full.
// When the receiver stalls, the output word holds steady until taken.
// Reset (rst_n low, asynchronous) empties the pipeline; nothing else is kept.
module rgb_to_hsl_converter_top
    import r2hsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  chan_t              red,
    input  chan_t              green,
    input  chan_t              blue,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [HUE_W-1:0]   hue,
    output logic [SAT_W-1:0]   saturation,
    output logic [LX2_W-1:0]   lightness_x2
);

    localparam int DS = DIV_STAGES;

    // stage 1: captured pixel
    logic  v1_reg;
    chan_t r1_reg, g1_reg, b1_reg;

    // stage 2: extremes and sector
    logic  v2_reg;
    chan_t r2_reg, g2_reg, b2_reg, hi2_reg, lo2_reg;
    logic  red_top2_reg, green_top2_reg, g_ge_b2_reg;
    chan_t hi2_next, lo2_next;
    logic  red_top2_next, green_top2_next, g_ge_b2_next;

    // stage 3: difference, sum, hue term, saturation divisor
    logic  v3_reg;
    chan_t d3_reg, den3_reg;
    sum_t  sum3_reg, t3_reg;
    hacc_t ofs3_reg;
    chan_t d3_next, den3_next;
    sum_t  sum3_next, t3_next;
    hacc_t ofs3_next;

    // divider stages
    logic [DS:0]     dv_reg;
    logic [DS:0]     en_d;
    div_t            dp_reg  [0:DS];
    div_t            dp_next [0:DS];
    logic [HN_W-1:0] hn;
    logic [SN_W-1:0] sn;

    // output stage
    logic             ov_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [SAT_W-1:0] sat_reg, sat_next;
    logic [LX2_W-1:0] lx2_reg, lx2_next;
    hacc_t            hsum;

    logic en_o, en3, en2, en1;

    assign en_o     = !ov_reg || result_ready;
    assign en_d[DS] = !dv_reg[DS] || en_o;

    genvar k;
    generate
        for (k = 0; k < DS; k++)
        begin : g_en
            assign en_d[k] = !dv_reg[k] || en_d[k+1];
        end
    endgenerate

    assign en3 = !v3_reg || en_d[0];
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pixel_ready = en1;

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            r1_reg <= red;
            g1_reg <= green;
            b1_reg <= blue;
        end
    end

    // stage 2
    always_comb
    begin
        red_top2_next   = (r1_reg >= g1_reg) && (r1_reg >= b1_reg);
        g_ge_b2_next    = (g1_reg >= b1_reg);
        green_top2_next = !red_top2_next && g_ge_b2_next;
        if (red_top2_next)
        begin
            hi2_next = r1_reg;
        end
        else if (g_ge_b2_next)
        begin
            hi2_next = g1_reg;
        end
        else
        begin
            hi2_next = b1_reg;
        end
        lo2_next = r1_reg;
        if (g1_reg < lo2_next)
        begin
            lo2_next = g1_reg;
        end
        if (b1_reg < lo2_next)
        begin
            lo2_next = b1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            r2_reg         <= r1_reg;
            g2_reg         <= g1_reg;
            b2_reg         <= b1_reg;
            hi2_reg        <= hi2_next;
            lo2_reg        <= lo2_next;
            red_top2_reg   <= red_top2_next;
            green_top2_reg <= green_top2_next;
            g_ge_b2_reg    <= g_ge_b2_next;
        end
    end

    // stage 3
    always_comb
    begin
        d3_next   = hi2_reg - lo2_reg;
        sum3_next = SUM_W'(hi2_reg) + SUM_W'(lo2_reg);
        if (sum3_next <= CH_MAX)
        begin
            den3_next = sum3_next[COMPONENT_BITS-1:0];
        end
        else
        begin
            den3_next = COMPONENT_BITS'(CH_MAX_X2 - sum3_next);
        end
        if (red_top2_reg && g_ge_b2_reg)
        begin
            t3_next   = SUM_W'(g2_reg) - SUM_W'(b2_reg);
            ofs3_next = HUE_OFS_RED_POS;
        end
        else if (red_top2_reg)
        begin
            t3_next   = SUM_W'(d3_next) + SUM_W'(g2_reg) - SUM_W'(b2_reg);
            ofs3_next = HUE_OFS_RED_NEG;
        end
        else if (green_top2_reg)
        begin
            t3_next   = SUM_W'(d3_next) + SUM_W'(b2_reg) - SUM_W'(r2_reg);
            ofs3_next = HUE_OFS_GREEN;
        end
        else
        begin
            t3_next   = SUM_W'(d3_next) + SUM_W'(r2_reg) - SUM_W'(g2_reg);
            ofs3_next = HUE_OFS_BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            d3_reg   <= d3_next;
            den3_reg <= den3_next;
            sum3_reg <= sum3_next;
            t3_reg   <= t3_next;
            ofs3_reg <= ofs3_next;
        end
    end

    // divider stage 0: rounded numerators, split into remainder and shift part
    always_comb
    begin
        hn = HN_W'(t3_reg) * HN_W'(HUE_SECTOR) + HN_W'(d3_reg >> 1);
        sn = SN_W'(d3_reg) * SAT_SCALE + SN_W'(den3_reg >> 1);
        dp_next[0].d    = d3_reg;
        dp_next[0].den  = den3_reg;
        dp_next[0].hrem = hn[HN_W-1:HQ_W];
        dp_next[0].hq   = hn[HQ_W-1:0];
        dp_next[0].srem = sn[SN_W-1:SQ_W];
        dp_next[0].sq   = sn[SQ_W-1:0];
        dp_next[0].ofs  = ofs3_reg;
        dp_next[0].sum  = sum3_reg;
        dp_next[0].zero = (d3_reg == '0);
    end

    generate
        for (k = 1; k <= DS; k++)
        begin : g_div
            assign dp_next[k] = div_step(dp_reg[k-1], 1'(k <= HQ_W), 1'(k <= SQ_W));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else
        begin
            if (en_d[0])
            begin
                dv_reg[0] <= v3_reg;
            end
            for (int i = 1; i <= DS; i++)
            begin
                if (en_d[i])
                begin
                    dv_reg[i] <= dv_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DS; i++)
        begin
            if (en_d[i])
            begin
                dp_reg[i] <= dp_next[i];
            end
        end
    end

    // output stage: add sector offset, wrap a full turn, zero hue and saturation of gray pixels
    always_comb
    begin
        hsum = dp_reg[DS].ofs + HA_W'(dp_reg[DS].hq);
        if (hsum >= FULL_TURN)
        begin
            hsum = hsum - FULL_TURN;
        end
        if (dp_reg[DS].zero)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = HUE_W'(hsum);
            sat_next = SAT_W'(dp_reg[DS].sq);
        end
        lx2_next = LX2_W'(dp_reg[DS].sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en_o)
        begin
            ov_reg <= dv_reg[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            lx2_reg <= lx2_next;
        end
    end

    assign result_valid = ov_reg;
    assign hue          = hue_reg;
    assign saturation   = sat_reg;
    assign lightness_x2 = lx2_reg;

endmodule

// ===== hw/rtl/r2hsl_checker.sv =====
`timescale 1ns / 1ps

`include "rgb_to_hsl_converter_top_defines.svh"

module r2hsl_checker
    import r2hsl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input logic [HUE_W-1:0] hue,
    input logic [SAT_W-1:0] saturation,
    input logic [LX2_W-1:0] lightness_x2
);

    `R2HSL_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(hue) && $stable(saturation) && $stable(lightness_x2))

    `R2HSL_ASSERT_NOW(a_hue_range, result_valid, hue < FULL_TURN && lightness_x2 != 9'd511)

    `R2HSL_ASSERT_NOW(a_hue_needs_sat, result_valid && hue != '0, saturation != '0)

    `R2HSL_ASSERT_NOW(a_sat_needs_spread, result_valid && saturation != '0, lightness_x2 != '0 && lightness_x2 != 9'd510)

endmodule

bind rgb_to_hsl_converter_top r2hsl_checker u_r2hsl_checker (.*);

// ===== tb/tb_rgb_to_hsl_converter_top.sv =====
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter_top;
    import r2hsl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_LEN = 300;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [LX2_W-1:0] lx2;
    } hsl_t;

    logic             clk;
    logic             rst_n;
    logic             pixel_valid;
    logic             pixel_ready;
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic             result_valid;
    logic             result_ready;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [LX2_W-1:0] lightness_x2;

    hsl_t hsl_due[$];
    int   mismatch_count;
    int   cycle_count;
    int   hold_off_left;
    bit   idling_on;

    rgb_to_hsl_converter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .hue          (hue),
        .saturation   (saturation),
        .lightness_x2 (lightness_x2)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic hsl_t hsl_of_pixel(input chan_t r, input chan_t g, input chan_t b);
        logic [63:0] rr, gg, bb, hi, lo, d, sum, den, num, h, s, unit, turn, cmax;
        hsl_t        res;
        rr   = 64'(r);
        gg   = 64'(g);
        bb   = 64'(b);
        unit = 64'd1 << HUE_FRAC_BITS;
        turn = 64'd360 * unit;
        cmax = (64'd1 << COMPONENT_BITS) - 64'd1;
        hi   = rr;
        lo   = rr;
        if (gg > hi) hi = gg;
        if (bb > hi) hi = bb;
        if (gg < lo) lo = gg;
        if (bb < lo) lo = bb;
        d    = hi - lo;
        sum  = hi + lo;
        h    = '0;
        s    = '0;
        if (d != 0)
        begin
            if (hi == rr)
            begin
                if (gg >= bb)
                    num = 64'd60 * unit * (gg - bb);
                else
                    num = turn * d - 64'd60 * unit * (bb - gg);
            end
            else if (hi == gg)
                num = 64'd120 * unit * d + 64'd60 * unit * bb - 64'd60 * unit * rr;
            else
                num = 64'd240 * unit * d + 64'd60 * unit * rr - 64'd60 * unit * gg;
            h = (num + d / 64'd2) / d;
            if (h >= turn) h = h - turn;
            den = (sum <= cmax) ? sum : (64'd2 * cmax - sum);
            s   = (64'd255 * d + den / 64'd2) / den;
        end
        res.hue = h[HUE_W-1:0];
        res.sat = s[SAT_W-1:0];
        res.lx2 = sum[LX2_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!idling_on || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (pixel_ready !== 1'b1) @(posedge clk);
        hsl_due.push_back(hsl_of_pixel(r, g, b));
    endtask

    task automatic end_stream();
        pixel_valid <= 1'b0;
        while (hsl_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_channel(output chan_t c);
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0: c = '0;
            1: c = chan_t'(1);
            2: c = '1;
            3: c = chan_t'((1 << COMPONENT_BITS) - 2);
            default: c = chan_t'($urandom);
        endcase
    endtask

    task automatic random_pixel(output chan_t r, output chan_t g, output chan_t b);
        int p;
        p = $urandom_range(0, 99);
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
        if (p < 10)
        begin
            g = r;
            b = r;
        end
        else if (p < 17)
            g = r;
        else if (p < 24)
            b = r;
        else if (p < 31)
            b = g;
        else if (p < 46)
        begin
            random_channel(r);
            random_channel(g);
            random_channel(b);
        end
    endtask

    task automatic test_extremes();
        idling_on = 1'b1;
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd254, 8'd255, 8'd255);
        end_stream();
    endtask

    task automatic test_hue_sectors();
        idling_on = 1'b1;
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd200, 8'd50,  8'd200);
        send_pixel(8'd50,  8'd200, 8'd200);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd255, 8'd128, 8'd200);
        send_pixel(8'd10,  8'd240, 8'd100);
        send_pixel(8'd90,  8'd30,  8'd250);
        send_pixel(8'd3,   8'd1,   8'd2);
        send_pixel(8'd170, 8'd85,  8'd0);
        end_stream();
    endtask

    task automatic test_random_pixels(input int count, input bit with_idling);
        chan_t r, g, b;
        idling_on = with_idling;
        repeat (count)
        begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        end_stream();
    endtask

    task automatic test_backpressure();
        chan_t r, g, b;
        idling_on     = 1'b0;
        hold_off_left = HOLD_OFF_LEN;
        repeat (80)
        begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        end_stream();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                result_ready  <= 1'b0;
                hold_off_left  = hold_off_left - 1;
            end
            else if (pick_gap() > 0)
                result_ready <= 1'b0;
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        hsl_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (hsl_due.size() == 0)
            begin
                $error("unexpected word: hue %0d sat %0d lx2 %0d",
                       hue, saturation, lightness_x2);
                mismatch_count++;
            end
            else
            begin
                want = hsl_due.pop_front();
                if (hue !== want.hue)
                begin
                    $error("hue: expected %0d, got %0d", want.hue, hue);
                    mismatch_count++;
                end
                if (saturation !== want.sat)
                begin
                    $error("saturation: expected %0d, got %0d", want.sat, saturation);
                    mismatch_count++;
                end
                if (lightness_x2 !== want.lx2)
                begin
                    $error("lightness_x2: expected %0d, got %0d", want.lx2, lightness_x2);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_rgb_to_hsl_converter_top: errors");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        hold_off_left  = 0;
        idling_on      = 1'b0;
        rst_n         <= 1'b0;
        pixel_valid   <= 1'b0;
        red           <= '0;
        green         <= '0;
        blue          <= '0;
        result_ready  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_hue_sectors();
        test_random_pixels(120, 1'b0);
        test_backpressure();
        test_random_pixels(300, 1'b1);
        if (mismatch_count == 0 && hsl_due.size() == 0)
            $display("tb_rgb_to_hsl_converter_top: clean");
        else
            $display("tb_rgb_to_hsl_converter_top: errors");
        $finish;
    end

endmodule
